### design/ellax_pkg.sv
// Shared widths and payload type for the ellipsoid axes pipeline.
`default_nettype none
package ellax_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int AXIS_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int RAD_W   = SQ_W + 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int ROOT_STAGES = ROOT_W;

    // Payload that rides alongside a root pipeline
    typedef struct packed {
        logic [COORD_W-1:0] mid_x;
        logic [COORD_W-1:0] mid_y;
        logic [COORD_W-1:0] mid_z;
        logic [SQ_W-1:0]    c_sq;
        logic [AXIS_W-1:0]  axis_a;
        logic               clamped;
    } side_t;

endpackage
`default_nettype wire

### design/ellax_root_pipe.sv
// Two-lane pipelined floor square root, one result bit per stage.
`default_nettype none
module ellax_root_pipe
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ellax_pkg::RAD_W-1:0] in_rad0,
    input  wire logic [ellax_pkg::RAD_W-1:0] in_rad1,
    input  wire ellax_pkg::side_t            in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ellax_pkg::ROOT_W-1:0]     out_root0,
    output logic [ellax_pkg::ROOT_W-1:0]     out_root1,
    output ellax_pkg::side_t                 out_side
);

    localparam int N = ellax_pkg::ROOT_STAGES;

    typedef struct packed {
        logic [ellax_pkg::RAD_W-1:0]  x;
        logic [ellax_pkg::ROOT_W-1:0] root;
        logic [ellax_pkg::REM_W-1:0]  rem;
    } lane_t;

    logic             valid_reg [N];
    lane_t            lane_reg  [N][2];
    ellax_pkg::side_t side_reg  [N];
    lane_t            lane_next [N][2];
    logic [N:0]       rdy;

    always_comb
    begin
        rdy[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    // one restoring step per stage: bring down two radicand bits, try root*4+1
    always_comb
    begin
        lane_t                      src;
        logic [ellax_pkg::REM_W-1:0] remsh;
        logic [ellax_pkg::REM_W-1:0] trial;
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (k == 0)
                begin
                    src.x    = (l == 0) ? in_rad0 : in_rad1;
                    src.root = '0;
                    src.rem  = '0;
                end
                else
                begin
                    src = lane_reg[k-1][l];
                end
                remsh = {src.rem[ellax_pkg::REM_W-3:0], src.x[ellax_pkg::RAD_W-1 -: 2]};
                trial = {1'b0, src.root, 2'b01};
                lane_next[k][l].x = {src.x[ellax_pkg::RAD_W-3:0], 2'b00};
                if (remsh >= trial)
                begin
                    lane_next[k][l].rem  = remsh - trial;
                    lane_next[k][l].root = {src.root[ellax_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    lane_next[k][l].rem  = remsh;
                    lane_next[k][l].root = {src.root[ellax_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (rdy[k])
            begin
                lane_reg[k][0] <= lane_next[k][0];
                lane_reg[k][1] <= lane_next[k][1];
                side_reg[k]    <= (k == 0) ? in_side : side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root0 = lane_reg[N-1][0].root;
    assign out_root1 = lane_reg[N-1][1].root;
    assign out_side  = side_reg[N-1];

endmodule
`default_nettype wire

### design/ellipsoid_axes_from_foci.sv
// Top level: ellipsoid center and semi-axes from two foci and a surface point.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | focus_a_*, focus_b_*, point_* (s24 Q11.12)
//  out     | out_valid/out_stall | mid_* (s24), semi_major, semi_minor
//          |                     | (u25 Q13.12), radicand_clamped
//
// One item per cycle sustained while out_stall is low. Items pass stages 1-3,
// a 26-stage bit-per-stage root pipe, stages 4-6, a second one, output reg.
// Every stage has its own valid bit and advances when empty or when the
// stage after it advances, so bubbles close up under an output stall.
// in_stall rises only when every stage holds an item.
// Reset (rst_n, async low) clears valid bits only.
`default_nettype none
module ellipsoid_axes_from_foci
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] focus_a_x,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] focus_a_y,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] focus_a_z,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] focus_b_x,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] focus_b_y,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] focus_b_z,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [ellax_pkg::COORD_W-1:0] point_z,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [ellax_pkg::COORD_W-1:0]  mid_x,
    output logic signed [ellax_pkg::COORD_W-1:0]  mid_y,
    output logic signed [ellax_pkg::COORD_W-1:0]  mid_z,
    output logic [ellax_pkg::AXIS_W-1:0]          semi_major,
    output logic [ellax_pkg::AXIS_W-1:0]          semi_minor,
    output logic                                  radicand_clamped
);

    localparam int CW = ellax_pkg::COORD_W;
    localparam int DW = ellax_pkg::DIFF_W;
    localparam int SW = ellax_pkg::SQ_W;
    localparam int RW = ellax_pkg::RAD_W;
    localparam int TW = ellax_pkg::ROOT_W;
    localparam int AW = ellax_pkg::AXIS_W;

    // ---- valid bits and advance enables ----
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    logic r1, r2, r3, r4, r5, r6, ro;
    logic p1_in_ready, p1_out_valid, p2_in_ready, p2_out_valid;

    assign ro = !vo_reg || !out_stall;
    assign r6 = !v6_reg || p2_in_ready;
    assign r5 = !v5_reg || r6;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || p1_in_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_stall = !r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= p1_out_valid;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
            if (ro) vo_reg <= p2_out_valid;
        end
    end

    // ---- stage 1: centers and absolute differences ----
    logic [DW-1:0] d_pa_next [3];
    logic [DW-1:0] d_pb_next [3];
    logic [DW-1:0] d_ab_next [3];
    logic [CW-1:0] ctr_next  [3];
    logic [DW-1:0] d_pa_reg  [3];
    logic [DW-1:0] d_pb_reg  [3];
    logic [DW-1:0] d_ab_reg  [3];
    logic [CW-1:0] ctr1_reg  [3];

    function automatic logic [DW-1:0] abs_diff(logic signed [CW-1:0] x,
                                               logic signed [CW-1:0] y);
        logic signed [DW-1:0] d;
        d = DW'(x) - DW'(y);
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    always_comb
    begin
        logic signed [CW-1:0] fa [3];
        logic signed [CW-1:0] fb [3];
        logic signed [CW-1:0] pp [3];
        logic signed [DW-1:0] s;
        fa[0] = focus_a_x; fa[1] = focus_a_y; fa[2] = focus_a_z;
        fb[0] = focus_b_x; fb[1] = focus_b_y; fb[2] = focus_b_z;
        pp[0] = point_x;   pp[1] = point_y;   pp[2] = point_z;
        for (int k = 0; k < 3; k++)
        begin
            s            = DW'(fa[k]) + DW'(fb[k]);
            ctr_next[k]  = s[DW-1:1];   // floor of half
            d_pa_next[k] = abs_diff(pp[k], fa[k]);
            d_pb_next[k] = abs_diff(pp[k], fb[k]);
            d_ab_next[k] = abs_diff(fa[k], fb[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            d_pa_reg <= d_pa_next;
            d_pb_reg <= d_pb_next;
            d_ab_reg <= d_ab_next;
            ctr1_reg <= ctr_next;
        end
    end

    // ---- stage 2: nine squares ----
    logic [SW-1:0] sq_pa_reg [3];
    logic [SW-1:0] sq_pb_reg [3];
    logic [SW-1:0] sq_ab_reg [3];
    logic [CW-1:0] ctr2_reg  [3];

    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_pa_reg[k] <= SW'(d_pa_reg[k]) * SW'(d_pa_reg[k]);
                sq_pb_reg[k] <= SW'(d_pb_reg[k]) * SW'(d_pb_reg[k]);
                sq_ab_reg[k] <= SW'(d_ab_reg[k]) * SW'(d_ab_reg[k]);
            end
            ctr2_reg <= ctr1_reg;
        end
    end

    // ---- stage 3: squared distances ----
    logic [SW-1:0]    dist_pa_reg, dist_pb_reg;
    ellax_pkg::side_t side3_reg;

    always_ff @(posedge clk)
    begin
        if (r3)
        begin
            dist_pa_reg       <= sq_pa_reg[0] + sq_pa_reg[1] + sq_pa_reg[2];
            dist_pb_reg       <= sq_pb_reg[0] + sq_pb_reg[1] + sq_pb_reg[2];
            side3_reg.c_sq    <= sq_ab_reg[0] + sq_ab_reg[1] + sq_ab_reg[2];
            side3_reg.mid_x   <= ctr2_reg[0];
            side3_reg.mid_y   <= ctr2_reg[1];
            side3_reg.mid_z   <= ctr2_reg[2];
            side3_reg.axis_a  <= '0;
            side3_reg.clamped <= 1'b0;
        end
    end

    // ---- focus distances ----
    logic [TW-1:0]    dist1, dist2;
    ellax_pkg::side_t side_p1;

    ellax_root_pipe u_root_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (p1_in_ready),
        .in_rad0   (RW'(dist_pa_reg)),
        .in_rad1   (RW'(dist_pb_reg)),
        .in_side   (side3_reg),
        .out_valid (p1_out_valid),
        .out_ready (r4),
        .out_root0 (dist1),
        .out_root1 (dist2),
        .out_side  (side_p1)
    );

    // ---- stage 4: semi-major axis ----
    ellax_pkg::side_t side4_reg;
    ellax_pkg::side_t side4_next;
    logic [TW:0]      dsum;

    assign dsum = (TW+1)'(dist1) + (TW+1)'(dist2);

    always_comb
    begin
        side4_next        = side_p1;
        side4_next.axis_a = dsum[AW:1];
    end

    always_ff @(posedge clk)
    begin
        if (r4)
        begin
            side4_reg <= side4_next;
        end
    end

    // ---- stage 5: (2a)^2 ----
    ellax_pkg::side_t side5_reg;
    logic [RW-1:0]    a_sq4_reg;

    always_ff @(posedge clk)
    begin
        if (r5)
        begin
            side5_reg <= side4_reg;
            a_sq4_reg <= RW'({side4_reg.axis_a, 1'b0}) * RW'({side4_reg.axis_a, 1'b0});
        end
    end

    // ---- stage 6: minor radicand with clamp ----
    ellax_pkg::side_t side6_reg;
    ellax_pkg::side_t side6_next;
    logic [RW-1:0]    minor_rad_reg;
    logic             clamp_next;

    assign clamp_next = a_sq4_reg < RW'(side5_reg.c_sq);

    always_comb
    begin
        side6_next         = side5_reg;
        side6_next.clamped = clamp_next;
    end

    always_ff @(posedge clk)
    begin
        if (r6)
        begin
            side6_reg     <= side6_next;
            minor_rad_reg <= clamp_next ? '0 : a_sq4_reg - RW'(side5_reg.c_sq);
        end
    end

    // ---- minor root (second lane idle) ----
    logic [TW-1:0]    root_b, root_unused;
    ellax_pkg::side_t side_p2;

    ellax_root_pipe u_root_minor
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_ready  (p2_in_ready),
        .in_rad0   (minor_rad_reg),
        .in_rad1   ('0),
        .in_side   (side6_reg),
        .out_valid (p2_out_valid),
        .out_ready (ro),
        .out_root0 (root_b),
        .out_root1 (root_unused),
        .out_side  (side_p2)
    );

    // ---- output register ----
    logic [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [AW-1:0] major_reg, minor_reg;
    logic          clamp_reg;

    always_ff @(posedge clk)
    begin
        if (ro)
        begin
            cx_reg    <= side_p2.mid_x;
            cy_reg    <= side_p2.mid_y;
            cz_reg    <= side_p2.mid_z;
            major_reg <= side_p2.axis_a;
            minor_reg <= root_b[TW-1:1] | AW'(root_unused & '0);
            clamp_reg <= side_p2.clamped;
        end
    end

    assign out_valid        = vo_reg;
    assign mid_x            = cx_reg;
    assign mid_y            = cy_reg;
    assign mid_z            = cz_reg;
    assign semi_major       = major_reg;
    assign semi_minor       = minor_reg;
    assign radicand_clamped = clamp_reg;

endmodule
`default_nettype wire

### design/ellax_checker.sv
// Port-level assertions for the ellipsoid axes block, bound to the top level.
`default_nettype none
module ellax_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [ellax_pkg::AXIS_W-1:0] semi_major,
    input wire logic [ellax_pkg::AXIS_W-1:0] semi_minor,
    input wire logic                        radicand_clamped
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(semi_major)
            && $stable(semi_minor) && $stable(radicand_clamped))
        else $error("result changed under stall");

    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && radicand_clamped |-> semi_minor == '0)
        else $error("clamped radicand with nonzero minor axis");

    a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> semi_minor <= semi_major)
        else $error("minor axis exceeds major axis");

    // input backs up only once the whole pipe is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while pipeline has room");

endmodule

bind ellipsoid_axes_from_foci ellax_checker u_ellax_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .semi_major       (semi_major),
    .semi_minor       (semi_minor),
    .radicand_clamped (radicand_clamped)
);
`default_nettype wire

### sim/tb.sv
// Testbench for ellipsoid_axes_from_foci: directed table plus random items, predictor check.
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int COORD_W = ellax_pkg::COORD_W;
    localparam int AXIS_W  = ellax_pkg::AXIS_W;
    localparam int LATENCY = 59;

    // One input item and one result item
    typedef struct {
        logic signed [COORD_W-1:0] fa [3];
        logic signed [COORD_W-1:0] fb [3];
        logic signed [COORD_W-1:0] pt [3];
    } geom_t;

    typedef struct {
        logic signed [COORD_W-1:0] ctr [3];
        logic [AXIS_W-1:0]         major;
        logic [AXIS_W-1:0]         minor;
        logic                      clamp;
    } axes_t;

    // Directed row: stimulus plus optional hand-typed expectation
    typedef struct {
        geom_t g;
        bit    typed;
        axes_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [COORD_W-1:0] fax, fay, faz, fbx, fby, fbz, px, py, pz;
    logic out_valid;
    logic out_stall;
    logic signed [COORD_W-1:0] mid_x, mid_y, mid_z;
    logic [AXIS_W-1:0] semi_major, semi_minor;
    logic radicand_clamped;

    axes_t axes_pending[$];
    int    mismatches;
    int    send_idle_pct;
    int    recv_idle_pct;

    ellipsoid_axes_from_foci i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .focus_a_x        (fax),
        .focus_a_y        (fay),
        .focus_a_z        (faz),
        .focus_b_x        (fbx),
        .focus_b_y        (fby),
        .focus_b_z        (fbz),
        .point_x          (px),
        .point_y          (py),
        .point_z          (pz),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mid_x            (mid_x),
        .mid_y            (mid_y),
        .mid_z            (mid_z),
        .semi_major       (semi_major),
        .semi_minor       (semi_minor),
        .radicand_clamped (radicand_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor square root of a wide unsigned value, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = r | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= x)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic [127:0] dist_sq(input logic signed [COORD_W-1:0] u [3],
                                             input logic signed [COORD_W-1:0] v [3]);
        logic [127:0] acc;
        logic signed [63:0] d;
        acc = '0;
        for (int k = 0; k < 3; k++)
        begin
            d = 64'(u[k]) - 64'(v[k]);
            if (d < 0)
                d = -d;
            acc += 128'(d) * 128'(d);
        end
        return acc;
    endfunction

    function automatic axes_t predict_axes(input geom_t g);
        axes_t r;
        logic signed [COORD_W:0] s;
        logic [63:0] d1, d2, a;
        logic [127:0] csq, a4;
        for (int k = 0; k < 3; k++)
        begin
            s = {g.fa[k][COORD_W-1], g.fa[k]} + {g.fb[k][COORD_W-1], g.fb[k]};
            r.ctr[k] = s[COORD_W:1];   // arithmetic shift rounds toward minus infinity
        end
        d1 = floor_sqrt(dist_sq(g.pt, g.fa));
        d2 = floor_sqrt(dist_sq(g.pt, g.fb));
        a = (d1 + d2) >> 1;
        csq = dist_sq(g.fa, g.fb);
        a4 = 128'(a << 1) * 128'(a << 1);
        r.major = a[AXIS_W-1:0];
        r.clamp = (a4 < csq);
        if (r.clamp)
            r.minor = '0;
        else
            r.minor = AXIS_W'(floor_sqrt(a4 - csq) >> 1);
        return r;
    endfunction

    function automatic geom_t mk(input int a0, a1, a2, b0, b1, b2, p0, p1, p2);
        geom_t g;
        g.fa[0] = COORD_W'(a0); g.fa[1] = COORD_W'(a1); g.fa[2] = COORD_W'(a2);
        g.fb[0] = COORD_W'(b0); g.fb[1] = COORD_W'(b1); g.fb[2] = COORD_W'(b2);
        g.pt[0] = COORD_W'(p0); g.pt[1] = COORD_W'(p1); g.pt[2] = COORD_W'(p2);
        return g;
    endfunction

    function automatic axes_t mk_axes(input int c0, c1, c2, mj, mn, cl);
        axes_t r;
        r.ctr[0] = COORD_W'(c0); r.ctr[1] = COORD_W'(c1); r.ctr[2] = COORD_W'(c2);
        r.major = AXIS_W'(mj); r.minor = AXIS_W'(mn); r.clamp = (cl != 0);
        return r;
    endfunction

    // Random coordinate: mostly small, sometimes full range or an extreme
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1, 2, 3: return COORD_W'($urandom);
            default: return COORD_W'($signed($urandom_range(0, 32767)) - 16384);
        endcase
    endfunction

    // Random item; some with coincident foci or point on a focus
    function automatic geom_t rand_geom();
        geom_t g;
        for (int k = 0; k < 3; k++)
        begin
            g.fa[k] = rand_coord();
            g.fb[k] = rand_coord();
            g.pt[k] = rand_coord();
        end
        case ($urandom_range(0, 9))
            0: g.fb = g.fa;
            1: g.pt = g.fa;
            2:
            begin
                // focal segment: point between the foci tends to clamp
                for (int k = 0; k < 3; k++)
                    g.pt[k] = COORD_W'((64'(g.fa[k]) + 64'(g.fb[k])) >>> 1);
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic send_item(input geom_t g, input bit typed, input axes_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        fax <= g.fa[0]; fay <= g.fa[1]; faz <= g.fa[2];
        fbx <= g.fb[0]; fby <= g.fb[1]; fbz <= g.fb[2];
        px  <= g.pt[0]; py  <= g.pt[1]; pz  <= g.pt[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // item accepted at this edge
        axes_pending.insert(axes_pending.size(), typed ? want : predict_axes(g));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (axes_pending.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall, checks each accepted result against oldest expectation
    always @(posedge clk)
    begin
        axes_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (axes_pending.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t", $realtime);
                end
                else
                begin
                    e = axes_pending.pop_front();
                    if (mid_x !== e.ctr[0] || mid_y !== e.ctr[1] ||
                        mid_z !== e.ctr[2] || semi_major !== e.major ||
                        semi_minor !== e.minor || radicand_clamped !== e.clamp)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp c=%0d,%0d,%0d a=%0d b=%0d cl=%0b",
                                      " got c=%0d,%0d,%0d a=%0d b=%0d cl=%0b"},
                                     e.ctr[0], e.ctr[1], e.ctr[2], e.major, e.minor,
                                     e.clamp, mid_x, mid_y, mid_z, semi_major,
                                     semi_minor, radicand_clamped);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        #20ms;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        axes_t none;
        int phase_items;

        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {fax, fay, faz, fbx, fby, fbz, px, py, pz} = '0;
        none = mk_axes(0, 0, 0, 0, 0, 0);

        // Directed table: typed expectations for trivial and error cases
        r.typed = 1; r.g = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.want = mk_axes(0, 0, 0, 0, 0, 0); rows.insert(rows.size(), r);
        // coincident foci: b equals a
        r.g = mk(0, 0, 0, 0, 0, 0, 4096, 0, 0);
        r.want = mk_axes(0, 0, 0, 4096, 4096, 0); rows.insert(rows.size(), r);
        // point midway between foci at distance 1 each: radicand exactly zero
        r.g = mk(-1, 0, 0, 1, 0, 0, 0, 0, 0);
        r.want = mk_axes(0, 0, 0, 1, 0, 0); rows.insert(rows.size(), r);
        // odd focal distance, point on a focus: the floored half-sum makes radicand negative
        r.g = mk(0, 0, 0, 3, 0, 0, 0, 0, 0);
        r.want = mk_axes(1, 0, 0, 1, 0, 1); rows.insert(rows.size(), r);
        // center of -1 and 0 rounds down; a floors to zero so the radicand clamps
        r.g = mk(-1, -1, -1, 0, 0, 0, 0, 0, 0);
        r.want = mk_axes(-1, -1, -1, 0, 0, 1); rows.insert(rows.size(), r);
        // predictor-checked extremes and mixed cases
        r.typed = 0; r.want = none;
        r.g = mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                 8388607, -8388608, 8388607); rows.insert(rows.size(), r);
        r.g = mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                 8388607, 8388607, 8388607); rows.insert(rows.size(), r);
        r.g = mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                 -8388608, -8388608, -8388608); rows.insert(rows.size(), r);
        r.g = mk(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                 0, 0, 0); rows.insert(rows.size(), r);
        r.g = mk(8388607, 0, 0, -8388608, 0, 0, 0, 8388607, 0); rows.insert(rows.size(), r);
        r.g = mk(1, 2, 3, 5, 7, 11, -13, 17, -19); rows.insert(rows.size(), r);
        r.g = mk(4096, 4096, 0, -4096, -4096, 0, 0, 0, 4096); rows.insert(rows.size(), r);
        r.g = mk(-5592405, 5592405, -1, 5592405, -5592405, 1,
                 2796202, 2796202, -2796203); rows.insert(rows.size(), r);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].g, rows[i].typed, rows[i].want);

        // sender holds off until every expected result has come
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 53 : 0;
            recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 15 : 0;
            phase_items = (ph == 2) ? 530 : 535;
            for (int n = 0; n < phase_items; n++)
                send_item(rand_geom(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (axes_pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0 && axes_pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
design/ellax_pkg.sv
design/ellax_root_pipe.sv
design/ellipsoid_axes_from_foci.sv
design/ellax_checker.sv
sim/tb.sv
